// ----- design/pst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, constants and helpers for the staging transform block.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int MAX_BEADS    = 32;
    localparam int BEAD_W       = 5;
    localparam int CFG_W        = 6;
    // Numerator of one bead combination: room for (2*MAX_BEADS) words
    localparam int NUM_W        = DATA_WIDTH + BEAD_W + 3;
    localparam int DEN_W        = BEAD_W + 1;
    localparam int DIV_BITS     = 8;
    localparam int DIV_CYC      = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_CYC + 1);
    localparam int LANES        = 3;

    typedef enum logic [1:0] {
        ACT_TO_STG   = 2'd0,
        ACT_FROM_STG = 2'd1,
        ACT_FORCE    = 2'd2,
        ACT_COPY     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_DIV,
        ST_TAIL,
        ST_ORD,
        ST_OLD
    } step_t;

    typedef enum logic [2:0] {
        PH_COPY,
        PH_HEAD,
        PH_SUM,
        PH_FIRST,
        PH_BODY
    } phase_t;

    typedef struct packed {
        action_t                        action;
        logic [BEAD_W-1:0]              bead;
        logic signed [DATA_WIDTH-1:0]   val_x;
        logic signed [DATA_WIDTH-1:0]   val_y;
        logic signed [DATA_WIDTH-1:0]   val_z;
        logic                           last;
    } load_t;

    typedef struct packed {
        logic [BEAD_W-1:0]              out_bead;
        logic signed [DATA_WIDTH-1:0]   res_x;
        logic signed [DATA_WIDTH-1:0]   res_y;
        logic signed [DATA_WIDTH-1:0]   res_z;
        logic                           out_last;
    } result_t;

    // Clamp a wide value into the signed data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_w(
        input logic signed [NUM_W-1:0] v
    );
        logic signed [NUM_W-1:0] hi;
        logic signed [NUM_W-1:0] lo;
        begin
            hi = $signed({{(NUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
            lo = $signed({{(NUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}});
            if (v > hi)
                sat_w = hi[DATA_WIDTH-1:0];
            else if (v < lo)
                sat_w = lo[DATA_WIDTH-1:0];
            else
                sat_w = v[DATA_WIDTH-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/pst_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pst_div
// Three-lane rounding divider by a small bead count, eight quotient bits
// per cycle, ties rounded away from zero.
// ----------------------------------------------------------------------------
module pst_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [pst_pkg::DEN_W-1:0]             den,
    input  wire logic signed [pst_pkg::NUM_W-1:0]      num [pst_pkg::LANES],
    output logic                                       done,
    output logic signed [pst_pkg::NUM_W-1:0]           quo [pst_pkg::LANES]
);

    localparam int NW = pst_pkg::NUM_W;
    localparam int DW = pst_pkg::DEN_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [pst_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]                den_reg;
    logic [NW-1:0]                mag_reg [pst_pkg::LANES];
    logic [NW-1:0]                mag_next [pst_pkg::LANES];
    logic [DW-1:0]                rem_reg [pst_pkg::LANES];
    logic [DW-1:0]                rem_next [pst_pkg::LANES];
    logic                         neg_reg [pst_pkg::LANES];

    always_comb
    begin
        logic [NW-1:0] m;
        logic [DW-1:0] r;
        logic [DW:0]   t;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        for (int j = 0; j < pst_pkg::LANES; j++)
        begin
            m = mag_reg[j];
            r = rem_reg[j];
            // shift the magnitude out and the quotient bits in
            for (int s = 0; s < pst_pkg::DIV_BITS; s++)
            begin
                t = {r, m[NW-1]};
                m = {m[NW-2:0], 1'b0};
                if (t >= {1'b0, den_reg})
                begin
                    t    = t - {1'b0, den_reg};
                    m[0] = 1'b1;
                end
                r = t[DW-1:0];
            end
            mag_next[j] = m;
            rem_next[j] = r;
        end
        if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pst_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pst_pkg::DIV_CNT_W'(pst_pkg::DIV_CYC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int j = 0; j < pst_pkg::LANES; j++)
            begin
                neg_reg[j] <= num[j][NW-1];
                mag_reg[j] <= (num[j][NW-1] ? NW'(-num[j]) : NW'(num[j]))
                              + NW'(den >> 1);
                rem_reg[j] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < pst_pkg::LANES; j++)
            begin
                mag_reg[j] <= mag_next[j];
                rem_reg[j] <= rem_next[j];
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int j = 0; j < pst_pkg::LANES; j++)
            quo[j] = neg_reg[j] ? -$signed(mag_reg[j]) : $signed(mag_reg[j]);
    end

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == pst_pkg::DIV_CNT_W'(pst_pkg::DIV_CYC))
        else $error("divider count not loaded");
`endif

endmodule
`default_nettype wire

// ----- design/pimd_staging_transform.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pimd_staging_transform
// Staging transform of one atom's bead ring, x, y and z side by side.
// ----------------------------------------------------------------------------
// Beads load one per cycle into the load memory while the block is idle; the
// request with last set starts the transform chosen by its action over
// num_beads beads, and the results then leave in bead order. Each bead that
// needs a division by its ratio denominator passes through a memory read,
// operand setup, the 8-bits-per-cycle divider and write-back; the force
// transform adds one pass per bead for the centroid sum. While draining, the
// next result memory read waits until the output register has been taken. No
// new load is taken from the last request until the final result sits in the
// output register.
module pimd_staging_transform (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load_valid,
    output logic                               load_ready,
    input  wire pst_pkg::load_t                load,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output pst_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pst_pkg::CFG_W-1:0]     cfg_data
);

    localparam int MAX_BEADS = pst_pkg::MAX_BEADS;
    localparam int W  = pst_pkg::DATA_WIDTH;
    localparam int NW = pst_pkg::NUM_W;
    localparam int BW = $clog2(MAX_BEADS);
    localparam int L  = pst_pkg::LANES;

    logic [3*W-1:0] ld_mem [MAX_BEADS];
    logic [3*W-1:0] rs_mem [MAX_BEADS];
    logic [3*W-1:0] ld_rd_reg;
    logic [3*W-1:0] rs_rd_reg;

    pst_pkg::step_t    state_reg, state_next;
    pst_pkg::phase_t   phase_reg, phase_next;
    pst_pkg::action_t  act_reg, act_next;
    logic [BW-1:0]     idx_reg, idx_next;
    logic [BW-1:0]     nm1_reg, nm1_next;
    logic [pst_pkg::CFG_W-1:0] num_beads_reg;
    logic              out_valid_reg, out_valid_next;
    pst_pkg::result_t  out_reg, out_next;

    logic signed [W-1:0]  a0_reg [L], a0_next [L];
    logic signed [W-1:0]  keep_reg [L], keep_next [L];
    logic signed [W-1:0]  hold_reg [L], hold_next [L];
    logic signed [NW-1:0] acc_reg [L], acc_next [L];

    logic signed [W-1:0]  a [L];
    logic signed [NW-1:0] ae [L];
    logic signed [NW-1:0] a0e [L];
    logic signed [NW-1:0] ke [L];
    logic signed [W-1:0]  r_w [L];
    logic [BW-1:0]        n_m1;
    logic                 ld_we;
    logic                 rs_we;
    logic [BW-1:0]        rs_waddr;

    logic                 div_start;
    logic                 div_done;
    logic [pst_pkg::DEN_W-1:0] div_den;
    logic signed [NW-1:0] div_num [L];
    logic signed [NW-1:0] div_quo [L];

    pst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .num   (div_num),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_ready    = 1'b1;
    assign load_ready   = (state_reg == pst_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        for (int j = 0; j < L; j++)
        begin
            a[j]   = $signed(ld_rd_reg[j*W +: W]);
            ae[j]  = NW'(a[j]);
            a0e[j] = NW'(a0_reg[j]);
            ke[j]  = NW'(keep_reg[j]);
        end
    end

    // Clamp the ring size to the storage depth
    always_comb
    begin
        if (num_beads_reg == '0)
            n_m1 = '0;
        else if (32'(num_beads_reg) > MAX_BEADS)
            n_m1 = BW'(MAX_BEADS - 1);
        else
            n_m1 = BW'(num_beads_reg - 1'b1);
    end

    always_comb
    begin
        logic signed [NW-1:0] k;
        state_next     = state_reg;
        phase_next     = phase_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        nm1_next       = nm1_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        a0_next        = a0_reg;
        keep_next      = keep_reg;
        hold_next      = hold_reg;
        acc_next       = acc_reg;
        ld_we          = 1'b0;
        rs_we          = 1'b0;
        rs_waddr       = idx_reg;
        div_start      = 1'b0;
        div_den        = pst_pkg::DEN_W'(idx_reg);
        k              = NW'(idx_reg);
        for (int j = 0; j < L; j++)
        begin
            r_w[j]     = a[j];
            div_num[j] = '0;
        end

        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            pst_pkg::ST_IDLE:
            begin
                if (load_valid)
                begin
                    ld_we = (32'(load.bead) < MAX_BEADS);
                    if (load.last)
                    begin
                        act_next   = load.action;
                        nm1_next   = n_m1;
                        idx_next   = '0;
                        state_next = pst_pkg::ST_RD;
                        for (int j = 0; j < L; j++)
                            acc_next[j] = '0;
                        if (n_m1 == '0 || load.action == pst_pkg::ACT_COPY)
                            phase_next = pst_pkg::PH_COPY;
                        else if (load.action == pst_pkg::ACT_FORCE)
                            phase_next = pst_pkg::PH_SUM;
                        else
                            phase_next = pst_pkg::PH_HEAD;
                    end
                end
            end
            pst_pkg::ST_RD:
            begin
                state_next = pst_pkg::ST_EX;
            end
            pst_pkg::ST_EX:
            begin
                state_next = pst_pkg::ST_RD;
                case (phase_reg)
                    pst_pkg::PH_COPY:
                    begin
                        rs_we = 1'b1;
                        if (idx_reg == nm1_reg)
                        begin
                            idx_next   = '0;
                            state_next = pst_pkg::ST_ORD;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                    pst_pkg::PH_HEAD:
                    begin
                        rs_we      = 1'b1;
                        a0_next    = a;
                        phase_next = pst_pkg::PH_FIRST;
                        idx_next   = (act_reg == pst_pkg::ACT_FROM_STG) ? nm1_reg : BW'(1);
                    end
                    pst_pkg::PH_SUM:
                    begin
                        for (int j = 0; j < L; j++)
                        begin
                            acc_next[j] = acc_reg[j] + ae[j];
                            r_w[j]      = pst_pkg::sat_w(acc_reg[j] + ae[j]);
                        end
                        if (idx_reg == nm1_reg)
                        begin
                            rs_we      = 1'b1;
                            rs_waddr   = '0;
                            idx_next   = BW'(1);
                            phase_next = pst_pkg::PH_FIRST;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                    pst_pkg::PH_FIRST:
                    begin
                        rs_we = 1'b1;
                        case (act_reg)
                            pst_pkg::ACT_TO_STG:
                            begin
                                // two beads: only the tail term is left
                                rs_we     = (nm1_reg == BW'(1));
                                keep_next = a;
                                for (int j = 0; j < L; j++)
                                    r_w[j] = pst_pkg::sat_w(ae[j] - a0e[j]);
                            end
                            pst_pkg::ACT_FROM_STG:
                            begin
                                for (int j = 0; j < L; j++)
                                begin
                                    r_w[j]       = pst_pkg::sat_w(ae[j] + a0e[j]);
                                    keep_next[j] = r_w[j];
                                end
                            end
                            default:
                            begin
                                keep_next = a;
                            end
                        endcase
                        if (nm1_reg == BW'(1))
                        begin
                            idx_next   = '0;
                            state_next = pst_pkg::ST_ORD;
                        end
                        else
                        begin
                            phase_next = pst_pkg::PH_BODY;
                            idx_next   = (act_reg == pst_pkg::ACT_FROM_STG)
                                         ? nm1_reg - 1'b1 : BW'(2);
                        end
                    end
                    pst_pkg::PH_BODY:
                    begin
                        hold_next  = a;
                        div_start  = 1'b1;
                        state_next = pst_pkg::ST_DIV;
                        case (act_reg)
                            pst_pkg::ACT_TO_STG:
                            begin
                                for (int j = 0; j < L; j++)
                                    div_num[j] = k * ke[j] - (k - 1) * ae[j] - a0e[j];
                            end
                            pst_pkg::ACT_FROM_STG:
                            begin
                                div_den = pst_pkg::DEN_W'(idx_reg) + 1'b1;
                                for (int j = 0; j < L; j++)
                                    div_num[j] = (k + 1) * ae[j] + k * ke[j] + a0e[j];
                            end
                            default:
                            begin
                                for (int j = 0; j < L; j++)
                                    div_num[j] = (k - 1) * ke[j];
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = pst_pkg::ST_IDLE;
                    end
                endcase
            end
            pst_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    rs_we      = 1'b1;
                    state_next = pst_pkg::ST_RD;
                    case (act_reg)
                        pst_pkg::ACT_TO_STG:
                        begin
                            rs_waddr  = idx_reg - 1'b1;
                            keep_next = hold_reg;
                            for (int j = 0; j < L; j++)
                                r_w[j] = pst_pkg::sat_w(div_quo[j]);
                            if (idx_reg == nm1_reg)
                                state_next = pst_pkg::ST_TAIL;
                            else
                                idx_next = idx_reg + 1'b1;
                        end
                        pst_pkg::ACT_FROM_STG:
                        begin
                            for (int j = 0; j < L; j++)
                            begin
                                r_w[j]       = pst_pkg::sat_w(div_quo[j]);
                                keep_next[j] = r_w[j];
                            end
                            if (idx_reg == BW'(1))
                            begin
                                idx_next   = '0;
                                state_next = pst_pkg::ST_ORD;
                            end
                            else
                                idx_next = idx_reg - 1'b1;
                        end
                        default:
                        begin
                            for (int j = 0; j < L; j++)
                            begin
                                r_w[j]       = pst_pkg::sat_w(NW'(hold_reg[j]) + div_quo[j]);
                                keep_next[j] = r_w[j];
                            end
                            if (idx_reg == nm1_reg)
                            begin
                                idx_next   = '0;
                                state_next = pst_pkg::ST_ORD;
                            end
                            else
                                idx_next = idx_reg + 1'b1;
                        end
                    endcase
                end
            end
            pst_pkg::ST_TAIL:
            begin
                rs_we    = 1'b1;
                rs_waddr = nm1_reg;
                for (int j = 0; j < L; j++)
                    r_w[j] = pst_pkg::sat_w(ke[j] - a0e[j]);
                idx_next   = '0;
                state_next = pst_pkg::ST_ORD;
            end
            pst_pkg::ST_ORD:
            begin
                // hold the read until the output register is free
                if (!out_valid_reg)
                    state_next = pst_pkg::ST_OLD;
            end
            pst_pkg::ST_OLD:
            begin
                out_valid_next    = 1'b1;
                out_next.out_bead = pst_pkg::BEAD_W'(idx_reg);
                out_next.res_x    = $signed(rs_rd_reg[0 +: W]);
                out_next.res_y    = $signed(rs_rd_reg[W +: W]);
                out_next.res_z    = $signed(rs_rd_reg[2*W +: W]);
                out_next.out_last = (idx_reg == nm1_reg);
                if (idx_reg == nm1_reg)
                    state_next = pst_pkg::ST_IDLE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = pst_pkg::ST_ORD;
                end
            end
            default:
            begin
                state_next = pst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pst_pkg::ST_IDLE;
            phase_reg     <= pst_pkg::PH_COPY;
            act_reg       <= pst_pkg::ACT_TO_STG;
            idx_reg       <= '0;
            nm1_reg       <= '0;
            out_valid_reg <= 1'b0;
            num_beads_reg <= pst_pkg::CFG_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            nm1_reg       <= nm1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                num_beads_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        a0_reg   <= a0_next;
        keep_reg <= keep_next;
        hold_reg <= hold_next;
        acc_reg  <= acc_next;
    end

    // Load and result memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ld_we)
            ld_mem[load.bead[BW-1:0]] <= {load.val_z, load.val_y, load.val_x};
        ld_rd_reg <= ld_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rs_we)
            rs_mem[rs_waddr] <= {r_w[2], r_w[1], r_w[0]};
        rs_rd_reg <= rs_mem[idx_reg];
    end

`ifndef NO_ASSERTIONS
    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pst_pkg::ST_OLD && idx_reg == nm1_reg)
        |=> state_reg == pst_pkg::ST_IDLE)
        else $error("drain did not end on the last bead");
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == pst_pkg::ST_DIV)
        else $error("divider result arrived outside the wait step");
    a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pst_pkg::ST_ORD && out_valid_reg && !result_ready)
        |=> state_reg == pst_pkg::ST_ORD && $stable(idx_reg))
        else $error("drain advanced over a pending result");
`endif

endmodule
`default_nettype wire

// ----- test/pimd_staging_transform_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pimd_staging_transform_test
// Loads bead rings with random and extreme values, starts each transform and
// checks every result against a bit-accurate predictor of the three staging
// transforms, under random idle bursts on both channels and several bead
// counts.
// ----------------------------------------------------------------------------

class staging_scoreboard;
    logic [5:0] bead_count;
    longint ld_x[pst_pkg::MAX_BEADS];
    longint ld_y[pst_pkg::MAX_BEADS];
    longint ld_z[pst_pkg::MAX_BEADS];
    pst_pkg::result_t pending[$];
    int errors;

    function new();
        bead_count = 6'd1;
        errors = 0;
        for (int i = 0; i < pst_pkg::MAX_BEADS; i++)
        begin
            ld_x[i] = 0;
            ld_y[i] = 0;
            ld_z[i] = 0;
        end
    endfunction

    function longint clamp(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties away from zero
    function longint round_div(longint num, longint d);
        if (num >= 0)
            return (num + d / 2) / d;
        return -((-num + d / 2) / d);
    endfunction

    function void stage(input longint a[pst_pkg::MAX_BEADS],
                        output longint r[pst_pkg::MAX_BEADS],
                        input int n, input pst_pkg::action_t act);
        longint s;
        longint d;
        for (int i = 0; i < pst_pkg::MAX_BEADS; i++)
            r[i] = 0;
        if (n <= 1 || act == pst_pkg::ACT_COPY)
        begin
            for (int i = 0; i < n; i++)
                r[i] = a[i];
        end
        else if (act == pst_pkg::ACT_TO_STG)
        begin
            r[0] = a[0];
            for (int i = 1; i + 1 < n; i++)
            begin
                d = i + 1;
                r[i] = clamp(round_div(d * a[i] - longint'(i) * a[i + 1] - a[0], d));
            end
            r[n - 1] = clamp(a[n - 1] - a[0]);
        end
        else if (act == pst_pkg::ACT_FROM_STG)
        begin
            r[0] = a[0];
            r[n - 1] = clamp(a[n - 1] + r[0]);
            for (int i = n - 2; i >= 1; i--)
            begin
                d = i + 1;
                r[i] = clamp(round_div(d * a[i] + longint'(i) * r[i + 1] + a[0], d));
            end
        end
        else
        begin
            s = 0;
            for (int i = 0; i < n; i++)
                s += a[i];
            r[0] = clamp(s);
            r[1] = a[1];
            for (int i = 1; i + 1 < n; i++)
            begin
                d = i + 1;
                r[i + 1] = clamp(a[i + 1] + round_div(longint'(i) * r[i], d));
            end
        end
    endfunction

    function void note_load(pst_pkg::load_t req);
        int n;
        longint rx[pst_pkg::MAX_BEADS];
        longint ry[pst_pkg::MAX_BEADS];
        longint rz[pst_pkg::MAX_BEADS];
        pst_pkg::result_t res;
        ld_x[req.bead] = longint'(req.val_x);
        ld_y[req.bead] = longint'(req.val_y);
        ld_z[req.bead] = longint'(req.val_z);
        if (!req.last)
            return;
        n = (bead_count == 0) ? 1 : ((bead_count > pst_pkg::MAX_BEADS)
            ? pst_pkg::MAX_BEADS : int'(bead_count));
        stage(ld_x, rx, n, req.action);
        stage(ld_y, ry, n, req.action);
        stage(ld_z, rz, n, req.action);
        for (int k = 0; k < n; k++)
        begin
            res.out_bead = k[pst_pkg::BEAD_W-1:0];
            res.res_x = rx[k][31:0];
            res.res_y = ry[k][31:0];
            res.res_z = rz[k][31:0];
            res.out_last = (k + 1 == n);
            pending.push_back(res);
        end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(pst_pkg::result_t got);
        pst_pkg::result_t want;
        if (pending.size() == 0)
        begin
            report("unexpected result bead", got.out_bead, 0);
            return;
        end
        want = pending.pop_front();
        if (got.out_bead !== want.out_bead) report("out_bead", got.out_bead, want.out_bead);
        if (got.res_x !== want.res_x) report("res_x", got.res_x, want.res_x);
        if (got.res_y !== want.res_y) report("res_y", got.res_y, want.res_y);
        if (got.res_z !== want.res_z) report("res_z", got.res_z, want.res_z);
        if (got.out_last !== want.out_last) report("out_last", got.out_last, want.out_last);
    endtask
endclass

module pimd_staging_transform_test;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic load_valid;
    logic load_ready;
    pst_pkg::load_t load;
    logic result_valid;
    logic result_ready;
    pst_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [pst_pkg::CFG_W-1:0] cfg_data;

    staging_scoreboard ring_check;
    bit calm;
    int idle_cycles = 0;

    pimd_staging_transform dut (
        .clk(clk),
        .rst_n(rst_n),
        .load_valid(load_valid),
        .load_ready(load_ready),
        .load(load),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: count cycles with no accepted request on any channel
    always @(posedge clk)
    begin
        if ((load_valid && load_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receive side with random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                ring_check.check_result(result);
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 8) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // valid stays up after acceptance; an idle burst or the drain drops it
    task automatic send_load(pst_pkg::action_t act, int bead, logic [31:0] vx,
                             logic [31:0] vy, logic [31:0] vz, bit is_last);
        pst_pkg::load_t req;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            load_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req.action = act;
        req.bead = bead[pst_pkg::BEAD_W-1:0];
        req.val_x = vx;
        req.val_y = vy;
        req.val_z = vz;
        req.last = is_last;
        load <= req;
        load_valid <= 1'b1;
        do
            @(posedge clk);
        while (!load_ready);
        ring_check.note_load(req);
    endtask

    task automatic wait_drained();
        load_valid <= 1'b0;
        while (ring_check.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_beads(logic [pst_pkg::CFG_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_check.bead_count = value;
    endtask

    // load beads 0..n-1 in random order, the final request starts the transform
    task automatic run_ring(int n, pst_pkg::action_t act, bit extremes);
        int order[$];
        int j;
        int tmp;
        logic [31:0] v;
        for (int i = 0; i < n; i++)
            order.push_back(i);
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < n; i++)
        begin
            v = extremes ? ((i % 2) ? 32'h7fffffff : 32'h80000000) : pick_value();
            send_load(act, order[i], v, pick_value(), extremes ? ~v : $urandom,
                      i == n - 1);
        end
        wait_drained();
    endtask

    initial
    begin
        int n;
        int loads;
        ring_check = new();
        calm = 1'b0;
        rst_n = 1'b0;
        load_valid = 1'b0;
        load = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single bead copy, every action at four beads, extremes, clamped counts
        run_ring(1, pst_pkg::ACT_TO_STG, 1'b0);
        set_beads(6'd4);
        run_ring(4, pst_pkg::ACT_TO_STG, 1'b1);
        run_ring(4, pst_pkg::ACT_FROM_STG, 1'b1);
        run_ring(4, pst_pkg::ACT_FORCE, 1'b1);
        send_load(pst_pkg::ACT_COPY, 2, 32'h12345678, 32'hedcba987, 32'h0, 1'b1);
        wait_drained();
        set_beads(6'd0);
        send_load(pst_pkg::ACT_FORCE, 0, 32'h7fffffff, 32'h80000000, 32'h1, 1'b1);
        wait_drained();
        set_beads(6'd63);
        run_ring(32, pst_pkg::ACT_FORCE, 1'b1);
        set_beads(6'd32);
        run_ring(32, pst_pkg::ACT_FROM_STG, 1'b0);

        // random rings, mostly small
        loads = 0;
        while (loads < 40)
        begin
            if (loads > 25)
                calm = 1'b1;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 8);
            set_beads(n[pst_pkg::CFG_W-1:0]);
            run_ring(n, pst_pkg::action_t'($urandom_range(0, 3)), 1'b0);
            loads += n;
        end
        wait_drained();

        if (ring_check.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
design/pst_pkg.sv
design/pst_div.sv
design/pimd_staging_transform.sv
test/pimd_staging_transform_test.sv
